// ----- design/text_console_cell_writer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Text console cell writer: assertion macros
// Concurrent check macros used by the core's checks. They expect
// clk_i and rst_ni in the scope of use.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define TCCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define TCCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer package
// Geometry constants, field widths, op codes and the shared structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tccw_pkg;

  // Store geometry
  localparam int unsigned MaxCols   = 160;
  localparam int unsigned MaxRows   = 64;
  localparam int unsigned CellCount = MaxCols * MaxRows;

  // Field widths
  localparam int unsigned CharW    = 8;
  localparam int unsigned ColW     = 8;
  localparam int unsigned RowW     = 6;
  localparam int unsigned HgtW     = 7;
  localparam int unsigned AddrW    = $clog2(CellCount);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Character codes
  localparam logic [CharW-1:0] NewlineCode = 8'd10;
  localparam logic [CharW-1:0] BlankCode   = 8'h20;

  // Reset geometry
  localparam logic [ColW-1:0]  WidthReset  = ColW'(MaxCols);
  localparam logic [HgtW-1:0]  HeightReset = HgtW'(MaxRows);
  localparam logic [AddrW-1:0] AreaReset   = AddrW'(CellCount);

  // Operation classes from the front end
  typedef enum logic [1:0] {
    OP_READ,
    OP_CHAR,
    OP_NEWLINE
  } tccw_op_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_LENGTH = 1'b0,
    REG_LINE_COUNT  = 1'b1
  } tccw_reg_e;

  // One classified item in the op queue
  typedef struct packed {
    tccw_op_e         op;
    logic [CharW-1:0] ch;
    logic [AddrW-1:0] rd_addr;
    logic             rd_hit;
  } tccw_entry_t;

  // Geometry in use
  typedef struct packed {
    logic [ColW-1:0]  width;
    logic [HgtW-1:0]  height;
    logic [AddrW-1:0] area;
  } tccw_geo_t;

  // Clamp column count to 1..MaxCols
  function automatic logic [ColW-1:0] sat_width(input logic [ColW-1:0] v);
    logic [ColW-1:0] r;
    if (v == '0) begin
      r = ColW'(1);
    end else if (v > ColW'(MaxCols)) begin
      r = ColW'(MaxCols);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Clamp row count to 1..MaxRows
  function automatic logic [HgtW-1:0] sat_height(input logic [HgtW-1:0] v);
    logic [HgtW-1:0] r;
    if (v == '0) begin
      r = HgtW'(1);
    end else if (v > HgtW'(MaxRows)) begin
      r = HgtW'(MaxRows);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- design/tccw_if.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer channels
// Valid/ready channel bundles for items, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Item channel
interface tccw_in_if import tccw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [CharW-1:0] char_byte;
  logic [RowW-1:0]  read_row;
  logic [ColW-1:0]  read_col;

  modport source (output valid, cmd, char_byte, read_row, read_col, input ready);
  modport sink   (input valid, cmd, char_byte, read_row, read_col, output ready);
endinterface

// Result channel
interface tccw_out_if import tccw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] cell_char;
  logic [ColW-1:0]  cur_col;
  logic [RowW-1:0]  cur_row;
  logic             did_scroll;

  modport source (output valid, cell_char, cur_col, cur_row, did_scroll, input ready);
  modport sink   (input valid, cell_char, cur_col, cur_row, did_scroll, output ready);
endinterface

// Register write channel
interface tccw_cfg_if import tccw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/tccw_front.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer front end
// Accepts items, sorts them into read / char / newline and works out the
// linear address and range hit of a read before it enters the op queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccw_front import tccw_pkg::*; (
  tccw_in_if.sink     in_i,
  input  tccw_geo_t   geo_i,
  input  logic        q_full_i,
  input  logic        clearing_i,
  output logic        push_o,
  output tccw_entry_t entry_o
);

  logic [RowW+ColW-1:0] row_base;

  // Take an item when the queue has room and the store is not being cleared
  assign in_i.ready = !q_full_i && !clearing_i;
  assign push_o     = in_i.valid && in_i.ready;

  // Linear cell address of a read: row * width + column
  assign row_base = in_i.read_row * geo_i.width;

  // Classify
  always_comb begin
    entry_o.ch      = in_i.char_byte;
    entry_o.rd_addr = AddrW'(row_base) + AddrW'(in_i.read_col);
    entry_o.rd_hit  = ({1'b0, in_i.read_row} < geo_i.height) &&
                      (in_i.read_col < geo_i.width);
    if (in_i.cmd) begin
      entry_o.op = OP_READ;
    end else if (in_i.char_byte == NewlineCode) begin
      entry_o.op = OP_NEWLINE;
    end else begin
      entry_o.op = OP_CHAR;
    end
  end

endmodule

// ----- design/tccw_queue.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer op queue
// Two-entry FIFO between the front end and the executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccw_queue import tccw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tccw_entry_t push_entry_i,
  input  logic        pop_i,
  output tccw_entry_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tccw_entry_t     slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- design/tccw_back.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer executor
// Owns the cell store and the cursor. Runs the clearing pass after reset,
// reads cells, writes characters, blanks the rest of the row on newline and scrolls the
// screen by copying every row up one and blanking the bottom row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tccw_back import tccw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tccw_geo_t   geo_i,
  input  tccw_entry_t head_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  output logic        clearing_o,
  tccw_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_BLANK,
    S_SCROLL,
    S_SC_LAST,
    S_FIN
  } state_e;

  state_e           state_q;
  tccw_op_e         op_q;
  logic [CharW-1:0] ch_q;
  logic             hit_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [AddrW-1:0] addr_q;
  logic [AddrW-1:0] bl_end_q;
  logic [AddrW-1:0] base_q;
  logic [ColW-1:0]  col_q;
  logic [RowW-1:0]  row_q;
  logic             scr_q;
  logic             pend_q;
  logic [AddrW-1:0] pend_addr_q;
  logic             pend_copy_q;
  logic             out_valid_q;
  logic [CharW-1:0] out_char_q;
  logic [ColW-1:0]  out_col_q;
  logic [RowW-1:0]  out_row_q;
  logic             out_scroll_q;

  // Cell store
  logic [CharW-1:0] mem [CellCount];
  logic [CharW-1:0] rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [CharW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr;

  logic [ColW-1:0]      w;
  logic [HgtW-1:0]      h;
  logic [ColW-1:0]      col_sat;
  logic [RowW-1:0]      row_sat;
  logic [RowW+ColW-1:0] base_prod;
  logic [AddrW-1:0]     cur_addr;
  logic [AddrW-1:0]     sc_src;
  logic                 sc_copy;
  logic                 col_last;
  logic                 row_last;
  logic                 out_free;

  assign w = geo_i.width;
  assign h = geo_i.height;

  // Cursor clamped into the geometry before a write
  assign col_sat   = (col_q >= w) ? w - ColW'(1) : col_q;
  assign row_sat   = ({1'b0, row_q} >= h) ? RowW'(h - HgtW'(1)) : row_q;
  assign base_prod = row_sat * w;

  assign cur_addr = base_q + AddrW'(col_q);
  assign col_last = (col_q == w - ColW'(1));
  assign row_last = ({1'b0, row_q} == h - HgtW'(1));

  // Scroll source is one row further on; past the used area it blanks
  assign sc_src  = addr_q + AddrW'(w);
  assign sc_copy = (sc_src < geo_i.area);

  assign out_free   = !out_valid_q || out_o.ready;
  assign q_pop_o    = (state_q == S_IDLE) && !q_empty_i;
  assign clearing_o = (state_q == S_CLEAR);

  assign out_o.valid      = out_valid_q;
  assign out_o.cell_char  = out_char_q;
  assign out_o.cur_col    = out_col_q;
  assign out_o.cur_row    = out_row_q;
  assign out_o.did_scroll = out_scroll_q;

  // Store port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = BlankCode;
    mem_raddr = rd_addr_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_raddr = head_i.rd_addr;
      end
      S_EXEC: begin
        mem_we    = (op_q == OP_CHAR) && out_free;
        mem_waddr = cur_addr;
        mem_wdata = ch_q;
      end
      S_BLANK: begin
        mem_we = 1'b1;
      end
      S_SCROLL, S_SC_LAST: begin
        mem_we    = pend_q;
        mem_waddr = pend_addr_q;
        mem_wdata = pend_copy_q ? rdata_q : BlankCode;
        mem_raddr = sc_copy ? sc_src : addr_q;
      end
      default: begin
        mem_raddr = rd_addr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Sequencer, cursor and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      op_q         <= OP_READ;
      ch_q         <= '0;
      hit_q        <= 1'b0;
      rd_addr_q    <= '0;
      addr_q       <= '0;
      bl_end_q     <= '0;
      base_q       <= '0;
      col_q        <= '0;
      row_q        <= '0;
      scr_q        <= 1'b0;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      pend_copy_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_char_q   <= BlankCode;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_scroll_q <= 1'b0;
    end else begin
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        // Blank every cell once after reset
        S_CLEAR: begin
          if (addr_q == AddrW'(CellCount - 1)) begin
            addr_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            addr_q <= addr_q + AddrW'(1);
          end
        end

        // Take the next op; writes clamp the cursor and fetch the row base
        S_IDLE: begin
          if (!q_empty_i) begin
            op_q      <= head_i.op;
            ch_q      <= head_i.ch;
            hit_q     <= head_i.rd_hit;
            rd_addr_q <= head_i.rd_addr;
            scr_q     <= 1'b0;
            if (head_i.op == OP_READ) begin
              state_q <= S_READ;
            end else begin
              col_q   <= col_sat;
              row_q   <= row_sat;
              base_q  <= AddrW'(base_prod);
              state_q <= S_EXEC;
            end
          end
        end

        // Cell data is back from the store
        S_READ: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_char_q   <= hit_q ? rdata_q : BlankCode;
            out_col_q    <= col_q;
            out_row_q    <= row_q;
            out_scroll_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end

        S_EXEC: begin
          unique case (op_q)
            OP_NEWLINE: begin
              addr_q   <= cur_addr;
              bl_end_q <= base_q + AddrW'(w) - AddrW'(1);
              state_q  <= S_BLANK;
            end
            OP_CHAR: begin
              if (out_free) begin
                if (!col_last) begin
                  col_q        <= col_q + ColW'(1);
                  out_valid_q  <= 1'b1;
                  out_char_q   <= BlankCode;
                  out_col_q    <= col_q + ColW'(1);
                  out_row_q    <= row_q;
                  out_scroll_q <= 1'b0;
                  state_q      <= S_IDLE;
                end else if (!row_last) begin
                  col_q        <= '0;
                  row_q        <= row_q + RowW'(1);
                  out_valid_q  <= 1'b1;
                  out_char_q   <= BlankCode;
                  out_col_q    <= '0;
                  out_row_q    <= row_q + RowW'(1);
                  out_scroll_q <= 1'b0;
                  state_q      <= S_IDLE;
                end else begin
                  col_q   <= '0;
                  scr_q   <= 1'b1;
                  addr_q  <= '0;
                  pend_q  <= 1'b0;
                  state_q <= S_SCROLL;
                end
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end

        // Blank the rest of the row, then wrap
        S_BLANK: begin
          addr_q <= addr_q + AddrW'(1);
          if (addr_q == bl_end_q) begin
            col_q <= '0;
            if (row_last) begin
              scr_q   <= 1'b1;
              addr_q  <= '0;
              pend_q  <= 1'b0;
              state_q <= S_SCROLL;
            end else begin
              row_q   <= row_q + RowW'(1);
              state_q <= S_FIN;
            end
          end
        end

        // Copy cell i+width to cell i over the used area, blank past the end
        S_SCROLL: begin
          pend_q      <= 1'b1;
          pend_addr_q <= addr_q;
          pend_copy_q <= sc_copy;
          if (addr_q == geo_i.area - AddrW'(1)) begin
            state_q <= S_SC_LAST;
          end else begin
            addr_q <= addr_q + AddrW'(1);
          end
        end

        // Last pending copy retires
        S_SC_LAST: begin
          pend_q  <= 1'b0;
          state_q <= S_FIN;
        end

        // Report cursor after a newline or a scroll
        S_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_char_q   <= BlankCode;
            out_col_q    <= col_q;
            out_row_q    <= row_q;
            out_scroll_q <= scr_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/text_console_cell_writer_core.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer core
// Character cell store of up to 160 columns by 64 rows with a cursor.
// in_i carries items: cmd 0 writes char_byte at the cursor (10 blanks the
// rest of the row and moves to the next row), cmd 1 reads the cell at
// read_row / read_col. out_o gives one result per item: the cell read (space
// on writes or off-screen reads), the cursor after the item and a scroll flag.
// cfg_i writes line_length (index 0) and line_count (index 1); it is always
// ready and should be used only while no item is in flight.
// Timing: an item is queued on its transfer edge. The executor fetches an op
// in its idle state and carries it out in its read or execute state; for a
// read or a plain character out_o.valid is registered there once the result
// register is free, and only then does the executor go back to idle for the
// next op. A newline blanks the rest of the row before its result is given.
// A scroll rewrites the used area one cell per cycle before its result.
// Reset: the cursor goes home, geometry returns to 160 x 64, and a clearing
// pass writes spaces to all 10240 cells; in_i.ready stays
// low until it ends. A stalled receiver holds the result register; the
// executor holds one more item and two wait in the queue before in_i.ready
// drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cell_writer_core import tccw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tccw_in_if.sink     in_i,
  tccw_cfg_if.sink    cfg_i,
  tccw_out_if.source  out_o
);

`include "text_console_cell_writer_core_assert.svh"

  logic [ColW-1:0]  width_q;
  logic [HgtW-1:0]  height_q;
  logic [AddrW-1:0] area_q;
  tccw_geo_t        geo;
  tccw_entry_t      push_entry;
  tccw_entry_t      head;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic             clearing;

  // Geometry registers, stored already clamped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      area_q   <= AreaReset;
    end else begin
      if (cfg_i.valid) begin
        unique case (tccw_reg_e'(cfg_i.index))
          REG_LINE_LENGTH: width_q  <= sat_width(cfg_i.data[ColW-1:0]);
          REG_LINE_COUNT:  height_q <= sat_height(cfg_i.data[HgtW-1:0]);
          default:         width_q  <= width_q;
        endcase
      end
      area_q <= AddrW'(width_q * height_q);
    end
  end

  assign geo.width  = width_q;
  assign geo.height = height_q;
  assign geo.area   = area_q;

  tccw_front u_front (
    .in_i       (in_i),
    .geo_i      (geo),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (q_push),
    .entry_o    (push_entry)
  );

  tccw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .pop_i        (q_pop),
    .head_o       (head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  tccw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .geo_i      (geo),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .out_o      (out_o)
  );

  // Checks
  `TCCW_ASSERT_IMP(a_no_take_in_clear, in_i.valid && in_i.ready, !clearing, "item taken in clear")
  `TCCW_ASSERT_IMP(a_no_push_full, q_push, !q_full, "push into full op queue")
  `TCCW_ASSERT_NXT(a_push_fills_queue, q_push, !q_empty, "pushed op missing from queue")
  `TCCW_ASSERT_IMP(a_no_result_in_clear, clearing, !out_o.valid, "result during clear")

endmodule

// ----- sim/text_console_cell_writer_core_test.sv -----
// ----------------------------------------------------------------------------
// Text console cell writer core testbench
// Drives character writes, newlines and cell reads through the item channel.
// Each phase programs a new geometry. Random idle on the sender and random
// stalls on the receiver are mixed in. A scoreboard keeps its own copy of
// the cell store, the cursor and the geometry, predicts one result per
// accepted item, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_cell_writer_core_test import tccw_pkg::*; ();

  // Item command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdRead  = 1'b1;

  // Run shape
  localparam int unsigned RandomItems   = 1150;
  localparam int unsigned CalmItems     = 150;
  localparam int unsigned BigArea       = 512;
  localparam int unsigned BigScrollCap  = 2;
  localparam int unsigned CycleLimit    = 10000000;
  localparam int unsigned ReportLimit   = 10;

  typedef struct packed {
    logic             cmd;
    logic [CharW-1:0] ch;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
  } console_item_t;

  typedef struct packed {
    logic [CharW-1:0] cell_char;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic             scroll;
  } console_view_t;

  // Console predictor and in-order result checker
  class console_scoreboard;
    logic [CharW-1:0] cells [CellCount];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [ColW-1:0]  len_reg;
    logic [HgtW-1:0]  cnt_reg;
    console_view_t    pending [$];
    int unsigned      failures;

    function new();
      foreach (cells[i]) cells[i] = BlankCode;
      col_pos  = 0;
      row_pos  = 0;
      len_reg  = WidthReset;
      cnt_reg  = HeightReset;
      failures = 0;
    endfunction

    function void set_reg(tccw_reg_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_LINE_LENGTH: len_reg = val[ColW-1:0];
        REG_LINE_COUNT:  cnt_reg = val[HgtW-1:0];
        default: ;
      endcase
    endfunction

    // Geometry in use, clamped to the store
    function int unsigned cols_used();
      if (len_reg == '0) return 1;
      if (len_reg > MaxCols) return MaxCols;
      return len_reg;
    endfunction

    function int unsigned rows_used();
      if (cnt_reg == '0) return 1;
      if (cnt_reg > MaxRows) return MaxRows;
      return cnt_reg;
    endfunction

    function int unsigned area();
      return cols_used() * rows_used();
    endfunction

    // True if a write of ch at the current cursor would scroll
    function bit will_scroll(logic [CharW-1:0] ch);
      int unsigned w, h, c, r;
      w = cols_used();
      h = rows_used();
      c = (col_pos >= w) ? w - 1 : col_pos;
      r = (row_pos >= h) ? h - 1 : row_pos;
      return (r == h - 1) && ((ch == NewlineCode) || (c == w - 1));
    endfunction

    // Apply one accepted item and queue the result it should give
    function console_view_t note_item(console_item_t it);
      int unsigned   w, h, base, i;
      console_view_t v;
      w = cols_used();
      h = rows_used();
      v.cell_char = BlankCode;
      v.scroll    = 1'b0;
      if (it.cmd == CmdRead) begin
        if (it.row < h && it.col < w) v.cell_char = cells[it.row * w + it.col];
      end else begin
        // cursor may sit outside a geometry that just shrank
        if (col_pos >= w) col_pos = w - 1;
        if (row_pos >= h) row_pos = h - 1;
        base = row_pos * w;
        if (it.ch == NewlineCode) begin
          for (i = col_pos; i < w; i++) cells[base + i] = BlankCode;
          col_pos = w;
        end else begin
          cells[base + col_pos] = it.ch;
          col_pos++;
        end
        // wrap, and scroll up one row past the bottom
        if (col_pos >= w) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= h) begin
            for (i = 0; i < w * (h - 1); i++) cells[i] = cells[i + w];
            for (i = w * (h - 1); i < w * h; i++) cells[i] = BlankCode;
            row_pos  = h - 1;
            v.scroll = 1'b1;
          end
        end
      end
      v.col = ColW'(col_pos);
      v.row = RowW'(row_pos);
      pending.push_back(v);
      return v;
    endfunction

    function void check_result(console_view_t got);
      console_view_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("%0t: result with nothing expected: cell %h col %0d row %0d scroll %b",
                   $time, got.cell_char, got.col, got.row, got.scroll);
        return;
      end
      want = pending.pop_front();
      if (got.cell_char !== want.cell_char || got.col !== want.col ||
          got.row !== want.row || got.scroll !== want.scroll) begin
        failures++;
        if (failures <= ReportLimit)
          $display("%0t: mismatch (exp/got) cell %h/%h col %0d/%0d row %0d/%0d scroll %b/%b",
                   $time, want.cell_char, got.cell_char, want.col, got.col, want.row,
                   got.row, want.scroll, got.scroll);
      end
    endfunction

    // Anything still queued never came out
    function void close_out();
      if (pending.size() != 0) begin
        failures += pending.size();
        $display("%0t: %0d results never arrived", $time, pending.size());
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  int unsigned sent_items = 0;

  console_scoreboard sb = new();

  tccw_in_if  in_if ();
  tccw_out_if out_if ();
  tccw_cfg_if cfg_if ();

  text_console_cell_writer_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** text_console_cell_writer_core: FAILED **");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result('{cell_char: out_if.cell_char, col: out_if.cur_col,
                        row: out_if.cur_row, scroll: out_if.did_scroll});
  end

  // Receiver: ready stretches of random length broken by stall bursts
  initial begin
    int unsigned span;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= 1'b1;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      repeat (span) @(posedge clk_i);
      if (!calm && $urandom_range(0, 99) < 70) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(posedge clk_i);
      end
    end
  end

  // One item transfer; valid stays high for a following item
  task automatic send_item(input console_item_t it, input int unsigned gap_pct,
                           output logic scrolled);
    console_view_t v;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= it.cmd;
    in_if.char_byte <= it.ch;
    in_if.read_row  <= it.row;
    in_if.read_col  <= it.col;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    v = sb.note_item(it);
    scrolled = v.scroll;
  endtask

  task automatic poke(input logic cmd, input logic [CharW-1:0] ch,
                      input logic [RowW-1:0] row, input logic [ColW-1:0] col);
    logic scrolled;
    send_item('{cmd: cmd, ch: ch, row: row, col: col}, 0, scrolled);
  endtask

  // Register write transfer; caller drops valid after the last one
  task automatic write_reg(input tccw_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_geometry(input logic [CfgDataW-1:0] len_raw,
                              input logic [CfgDataW-1:0] cnt_raw);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_LINE_LENGTH, len_raw);
      write_reg(REG_LINE_COUNT, cnt_raw);
    end else begin
      write_reg(REG_LINE_COUNT, cnt_raw);
      write_reg(REG_LINE_LENGTH, len_raw);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Drain results, then give a pending scroll or row clear time to finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (sb.area() + 200) @(posedge clk_i);
  endtask

  function automatic console_item_t pick_item(int unsigned nl_pct, int unsigned rd_pct);
    console_item_t it;
    int unsigned   w, h;
    w = sb.cols_used();
    h = sb.rows_used();
    it.cmd = ($urandom_range(0, 99) < rd_pct) ? CmdRead : CmdWrite;
    it.ch  = ($urandom_range(0, 99) < nl_pct) ? NewlineCode : CharW'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 20) begin
      it.row = RowW'($urandom_range(0, 63));
      it.col = ColW'($urandom_range(0, 255));
    end else begin
      it.row = RowW'($urandom_range(0, h - 1));
      it.col = ColW'($urandom_range(0, w - 1));
    end
    return it;
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned nl_pct,
                           input int unsigned rd_pct, input int unsigned gap_pct);
    console_item_t it;
    int unsigned   k, big_scrolls;
    logic          scrolled;
    big_scrolls = 0;
    for (k = 0; k < n && sent_items < RandomItems; k++) begin
      it = pick_item(nl_pct, rd_pct);
      // scrolls over a large area are slow; allow only a couple per phase
      if (it.cmd == CmdWrite && sb.area() > BigArea && big_scrolls >= BigScrollCap &&
          sb.will_scroll(it.ch))
        it.cmd = CmdRead;
      send_item(it, gap_pct, scrolled);
      if (scrolled && sb.area() > BigArea) big_scrolls++;
      sent_items++;
      if (sent_items + CalmItems >= RandomItems) calm = 1'b1;
    end
  endtask

  // Main sequence
  initial begin
    int unsigned          phase, n, nl_pct, rd_pct, gap_pct;
    logic [CfgDataW-1:0]  len_raw, cnt_raw;

    in_if.valid     <= 1'b0;
    in_if.cmd       <= CmdWrite;
    in_if.char_byte <= '0;
    in_if.read_row  <= '0;
    in_if.read_col  <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_LINE_LENGTH;
    cfg_if.data     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: cleared store, field extremes, newline handling, read-back
    poke(CmdRead, 8'h00, 6'd0, 8'd0);
    poke(CmdRead, 8'hff, 6'd63, 8'd159);
    poke(CmdRead, 8'h00, 6'd0, 8'd160);
    poke(CmdRead, 8'hff, 6'd63, 8'd255);
    poke(CmdWrite, 8'h00, 6'd0, 8'd0);
    poke(CmdWrite, 8'hff, 6'd63, 8'd255);
    poke(CmdWrite, 8'h41, 6'd0, 8'd0);
    poke(CmdWrite, NewlineCode, 6'd0, 8'd0);
    poke(CmdWrite, NewlineCode, 6'd0, 8'd0);   // newline at column zero
    poke(CmdWrite, 8'h7e, 6'd0, 8'd0);
    poke(CmdWrite, 8'h0b, 6'd0, 8'd0);
    poke(CmdWrite, 8'h09, 6'd0, 8'd0);
    poke(CmdWrite, BlankCode, 6'd0, 8'd0);
    poke(CmdWrite, 8'h7f, 6'd0, 8'd0);
    poke(CmdRead, 8'h00, 6'd0, 8'd0);
    poke(CmdRead, 8'h00, 6'd0, 8'd1);
    poke(CmdRead, 8'h00, 6'd0, 8'd2);
    poke(CmdRead, 8'h00, 6'd0, 8'd3);
    poke(CmdRead, 8'h00, 6'd1, 8'd0);
    poke(CmdRead, 8'h00, 6'd2, 8'd4);
    poke(CmdRead, 8'h00, 6'd2, 8'd5);
    settle();

    // Random phases, each with its own geometry
    phase = 0;
    while (sent_items < RandomItems) begin
      n       = $urandom_range(30, 80);
      nl_pct  = 12;
      rd_pct  = 40;
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 15;
        default: gap_pct = 40;
      endcase
      case (phase)
        0: begin len_raw = 8'd4;   cnt_raw = 8'd2;   rd_pct = 50; end  // cursor left outside
        1: begin len_raw = 8'd0;   cnt_raw = 8'd0;   end
        2: begin len_raw = 8'd1;   cnt_raw = 8'd64;  end
        3: begin len_raw = 8'd160; cnt_raw = 8'd1;   nl_pct = 30; end
        4: begin len_raw = 8'd255; cnt_raw = 8'd127; n = 130; nl_pct = 70; rd_pct = 20; end
        5: begin len_raw = 8'd2;   cnt_raw = 8'd3;   end
        6: begin len_raw = 8'd160; cnt_raw = 8'd64;  n = 100; nl_pct = 60; rd_pct = 25; end
        7: begin len_raw = 8'd1;   cnt_raw = 8'd128; end              // count bit 7 dropped
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 6))
              0: len_raw = 8'd0;
              1: len_raw = 8'd1;
              2: len_raw = 8'd159;
              3: len_raw = 8'd160;
              4: len_raw = 8'd161;
              5: len_raw = 8'd255;
              default: len_raw = CfgDataW'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 8))
              0: cnt_raw = 8'd0;
              1: cnt_raw = 8'd1;
              2: cnt_raw = 8'd63;
              3: cnt_raw = 8'd64;
              4: cnt_raw = 8'd65;
              5: cnt_raw = 8'd127;
              6: cnt_raw = 8'd128;
              7: cnt_raw = 8'd255;
              default: cnt_raw = CfgDataW'($urandom_range(0, 255));
            endcase
            n      = 60;
            nl_pct = 50;
            rd_pct = 30;
          end else begin
            len_raw = CfgDataW'($urandom_range(1, 12));
            cnt_raw = CfgDataW'($urandom_range(1, 6));
          end
        end
      endcase
      set_geometry(len_raw, cnt_raw);
      run_phase(n, nl_pct, rd_pct, gap_pct);
      settle();
      phase++;
    end

    sb.close_out();
    if (sb.failures == 0) begin
      $display("** text_console_cell_writer_core: PASSED **");
    end else begin
      $display("** text_console_cell_writer_core: FAILED **");
    end
    $finish;
  end

endmodule
